@@ hw/rtl/mms_pkg.sv @@
// shared types and constants for the min/max stack
`default_nettype none

package mms_pkg;

    localparam int DEPTH_DEF      = 16;
    localparam int DATA_WIDTH_DEF = 32;

    typedef enum logic [1:0] {
        ACT_QUERY = 2'd0,
        ACT_PUSH  = 2'd1,
        ACT_POP   = 2'd2
    } t_action;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_OVERFLOW  = 2'd1,
        ST_UNDERFLOW = 2'd2
    } t_status;

    typedef struct packed {
        t_status status;
        logic    is_empty;
        logic    is_full;
    } t_flags;

endpackage

`default_nettype wire

@@ hw/rtl/stack_with_max_min_query.sv @@
// Bounded LIFO stack of signed words with push, pop and query, reporting the
// popped word, a status code, empty/full flags, the entry count and the
// highest and lowest stored values after every transaction. One transaction
// is taken per clock cycle while input ready is high; its result is
// registered in the result buffer. The top level is held in registers and
// the level below it is prefetched every cycle from a DEPTH-row memory
// through its single read port. Highest and lowest come from per-level
// running max and min stored alongside each word. A two-entry result buffer
// lets one further transaction be accepted while a result is stalled; input
// ready drops only when both entries are occupied. No clearing pass is
// needed after reset.
`default_nettype none

module stack_with_max_min_query #(
    parameter int DEPTH      = mms_pkg::DEPTH_DEF,
    parameter int DATA_WIDTH = mms_pkg::DATA_WIDTH_DEF
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_in_valid,
    output logic                                 o_in_ready,
    input  wire logic [1:0]                      i_action,
    input  wire logic signed [DATA_WIDTH-1:0]    i_push_value,
    output logic                                 o_out_valid,
    input  wire logic                            i_out_ready,
    output logic signed [DATA_WIDTH-1:0]         o_popped_value,
    output logic [1:0]                           o_status,
    output logic                                 o_is_empty,
    output logic                                 o_is_full,
    output logic [$clog2(DEPTH+1)-1:0]           o_entry_count,
    output logic signed [DATA_WIDTH-1:0]         o_highest,
    output logic signed [DATA_WIDTH-1:0]         o_lowest
);

    localparam int CW = $clog2(DEPTH + 1);

    logic                         w_fire;
    logic signed [DATA_WIDTH-1:0] w_popped_value;
    mms_pkg::t_flags              w_flags;
    logic [CW-1:0]                w_entry_count;
    logic signed [DATA_WIDTH-1:0] w_highest;
    logic signed [DATA_WIDTH-1:0] w_lowest;
    mms_pkg::t_flags              w_out_flags;

    assign w_fire = i_in_valid && o_in_ready;

    mms_core #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_core (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_fire         (w_fire),
        .i_action       (i_action),
        .i_push_value   (i_push_value),
        .o_popped_value (w_popped_value),
        .o_flags        (w_flags),
        .o_entry_count  (w_entry_count),
        .o_highest      (w_highest),
        .o_lowest       (w_lowest)
    );

    mms_outq #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_outq (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_fire         (w_fire),
        .i_popped_value (w_popped_value),
        .i_flags        (w_flags),
        .i_entry_count  (w_entry_count),
        .i_highest      (w_highest),
        .i_lowest       (w_lowest),
        .i_out_ready    (i_out_ready),
        .o_in_ready     (o_in_ready),
        .o_out_valid    (o_out_valid),
        .o_popped_value (o_popped_value),
        .o_flags        (w_out_flags),
        .o_entry_count  (o_entry_count),
        .o_highest      (o_highest),
        .o_lowest       (o_lowest)
    );

    assign o_status   = w_out_flags.status;
    assign o_is_empty = w_out_flags.is_empty;
    assign o_is_full  = w_out_flags.is_full;

endmodule

`default_nettype wire

@@ hw/rtl/mms_core.sv @@
// stack state, level memory with cached top level, and per-transaction result logic
`default_nettype none

module mms_core #(
    parameter int DEPTH      = mms_pkg::DEPTH_DEF,
    parameter int DATA_WIDTH = mms_pkg::DATA_WIDTH_DEF
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_fire,
    input  wire logic [1:0]                      i_action,
    input  wire logic signed [DATA_WIDTH-1:0]    i_push_value,
    output logic signed [DATA_WIDTH-1:0]         o_popped_value,
    output mms_pkg::t_flags                      o_flags,
    output logic [$clog2(DEPTH+1)-1:0]           o_entry_count,
    output logic signed [DATA_WIDTH-1:0]         o_highest,
    output logic signed [DATA_WIDTH-1:0]         o_lowest
);

    localparam int CW = $clog2(DEPTH + 1);
    localparam int AW = $clog2(DEPTH);
    localparam int MW = 3 * DATA_WIDTH;
    localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);

    logic [CW-1:0]                r_count;
    logic [CW-1:0]                n_count;
    logic signed [DATA_WIDTH-1:0] r_top_val;
    logic signed [DATA_WIDTH-1:0] r_top_max;
    logic signed [DATA_WIDTH-1:0] r_top_min;
    logic signed [DATA_WIDTH-1:0] n_top_val;
    logic signed [DATA_WIDTH-1:0] n_top_max;
    logic signed [DATA_WIDTH-1:0] n_top_min;
    logic [MW-1:0]                r_second;
    logic [MW-1:0]                r_mem [DEPTH];

    logic signed [DATA_WIDTH-1:0] w_new_max;
    logic signed [DATA_WIDTH-1:0] w_new_min;
    logic signed [DATA_WIDTH-1:0] w_popped;
    mms_pkg::t_status             w_status;
    logic                         w_wr_en;
    logic [CW-1:0]                w_rd_full;
    logic [AW-1:0]                w_rd_addr;

    // running max and min of the level being pushed
    assign w_new_max = (r_count == '0 || i_push_value > r_top_max) ? i_push_value : r_top_max;
    assign w_new_min = (r_count == '0 || i_push_value < r_top_min) ? i_push_value : r_top_min;

    always_comb begin
        n_count   = r_count;
        n_top_val = r_top_val;
        n_top_max = r_top_max;
        n_top_min = r_top_min;
        w_popped  = '0;
        w_status  = mms_pkg::ST_OK;
        w_wr_en   = 1'b0;
        if (i_fire) begin
            case (mms_pkg::t_action'(i_action))
                mms_pkg::ACT_PUSH: begin
                    if (r_count == FULL_COUNT) begin
                        w_status = mms_pkg::ST_OVERFLOW;
                    end else begin
                        n_count   = r_count + CW'(1);
                        n_top_val = i_push_value;
                        n_top_max = w_new_max;
                        n_top_min = w_new_min;
                        w_wr_en   = 1'b1;
                    end
                end
                mms_pkg::ACT_POP: begin
                    if (r_count == '0) begin
                        w_status = mms_pkg::ST_UNDERFLOW;
                    end else begin
                        n_count   = r_count - CW'(1);
                        w_popped  = r_top_val;
                        n_top_val = r_second[MW-1 -: DATA_WIDTH];
                        n_top_max = r_second[2*DATA_WIDTH-1 -: DATA_WIDTH];
                        n_top_min = r_second[DATA_WIDTH-1:0];
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // level just below the next top, prefetched for a following pop
    assign w_rd_full = n_count - CW'(2);
    assign w_rd_addr = w_rd_full[AW-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        r_top_val <= n_top_val;
        r_top_max <= n_top_max;
        r_top_min <= n_top_min;
    end

    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            r_mem[r_count[AW-1:0]] <= {i_push_value, w_new_max, w_new_min};
        end
        r_second <= r_mem[w_rd_addr];
    end

    assign o_popped_value   = w_popped;
    assign o_flags.status   = w_status;
    assign o_flags.is_empty = (n_count == '0);
    assign o_flags.is_full  = (n_count == FULL_COUNT);
    assign o_entry_count    = n_count;
    assign o_highest        = (n_count != '0) ? n_top_max : '0;
    assign o_lowest         = (n_count != '0) ? n_top_min : '0;

endmodule

`default_nettype wire

@@ hw/rtl/mms_outq.sv @@
// two-entry result buffer: result register plus skid register
`default_nettype none

module mms_outq #(
    parameter int DEPTH      = mms_pkg::DEPTH_DEF,
    parameter int DATA_WIDTH = mms_pkg::DATA_WIDTH_DEF
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_fire,
    input  wire logic signed [DATA_WIDTH-1:0]    i_popped_value,
    input  wire mms_pkg::t_flags                 i_flags,
    input  wire logic [$clog2(DEPTH+1)-1:0]      i_entry_count,
    input  wire logic signed [DATA_WIDTH-1:0]    i_highest,
    input  wire logic signed [DATA_WIDTH-1:0]    i_lowest,
    input  wire logic                            i_out_ready,
    output logic                                 o_in_ready,
    output logic                                 o_out_valid,
    output logic signed [DATA_WIDTH-1:0]         o_popped_value,
    output mms_pkg::t_flags                      o_flags,
    output logic [$clog2(DEPTH+1)-1:0]           o_entry_count,
    output logic signed [DATA_WIDTH-1:0]         o_highest,
    output logic signed [DATA_WIDTH-1:0]         o_lowest
);

    localparam int CW = $clog2(DEPTH + 1);
    localparam int FW = $bits(mms_pkg::t_flags);
    localparam int RW = 3 * DATA_WIDTH + CW + FW;

    logic [RW-1:0] r_main;
    logic [RW-1:0] r_skid;
    logic [RW-1:0] n_main;
    logic [RW-1:0] n_skid;
    logic          r_main_valid;
    logic          r_skid_valid;
    logic          n_main_valid;
    logic          n_skid_valid;
    logic [RW-1:0] w_new;
    logic          w_take;

    assign w_new  = {i_popped_value, i_entry_count, i_highest, i_lowest, i_flags};
    assign w_take = r_main_valid && i_out_ready;

    always_comb begin
        n_main       = r_main;
        n_skid       = r_skid;
        n_main_valid = r_main_valid;
        n_skid_valid = r_skid_valid;
        if (r_skid_valid) begin
            if (w_take) begin
                n_main       = r_skid;
                n_skid_valid = 1'b0;
            end
        end else if (i_fire) begin
            if (!r_main_valid || w_take) begin
                n_main       = w_new;
                n_main_valid = 1'b1;
            end else begin
                n_skid       = w_new;
                n_skid_valid = 1'b1;
            end
        end else if (w_take) begin
            n_main_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_main_valid <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_main_valid <= n_main_valid;
            r_skid_valid <= n_skid_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_main <= n_main;
        r_skid <= n_skid;
    end

    assign o_in_ready     = !r_skid_valid;
    assign o_out_valid    = r_main_valid;
    assign o_popped_value = r_main[RW-1 -: DATA_WIDTH];
    assign o_entry_count  = r_main[RW-DATA_WIDTH-1 -: CW];
    assign o_highest      = r_main[2*DATA_WIDTH+FW-1 -: DATA_WIDTH];
    assign o_lowest       = r_main[DATA_WIDTH+FW-1 -: DATA_WIDTH];
    assign o_flags        = mms_pkg::t_flags'(r_main[FW-1:0]);

endmodule

`default_nettype wire

@@ hw/rtl/mms_chk.sv @@
// port-level checker for the min/max stack, bound to the top level
`default_nettype none

module mms_chk #(
    parameter int DEPTH      = mms_pkg::DEPTH_DEF,
    parameter int DATA_WIDTH = mms_pkg::DATA_WIDTH_DEF
) (
    input wire logic                            i_clk,
    input wire logic                            i_rst_n,
    input wire logic                            o_out_valid,
    input wire logic                            i_out_ready,
    input wire logic signed [DATA_WIDTH-1:0]    o_popped_value,
    input wire logic [1:0]                      o_status,
    input wire logic                            o_is_empty,
    input wire logic                            o_is_full,
    input wire logic [$clog2(DEPTH+1)-1:0]      o_entry_count,
    input wire logic signed [DATA_WIDTH-1:0]    o_highest,
    input wire logic signed [DATA_WIDTH-1:0]    o_lowest
);

    localparam int CW = $clog2(DEPTH + 1);

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_popped_value)
            && $stable(o_entry_count) && $stable(o_highest) && $stable(o_lowest)
            && $stable(o_status))
        else $error("result changed while stalled");

    a_flags_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_is_empty == (o_entry_count == '0))
            && (o_is_full == (o_entry_count == CW'(DEPTH))))
        else $error("empty/full flags disagree with entry count");

    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_is_empty |-> o_highest == '0 && o_lowest == '0)
        else $error("highest/lowest not zero on empty stack");

    a_refusal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_status == mms_pkg::ST_OVERFLOW || o_status == mms_pkg::ST_UNDERFLOW)
            |-> o_popped_value == '0
            && (o_status != mms_pkg::ST_OVERFLOW || o_is_full)
            && (o_status != mms_pkg::ST_UNDERFLOW || o_is_empty))
        else $error("refused transaction with inconsistent state");

    a_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_is_empty |-> o_lowest <= o_highest)
        else $error("lowest above highest");

endmodule

bind stack_with_max_min_query mms_chk #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
) u_mms_chk (.*);

`default_nettype wire
